// File: rtl/core/msb_pkg.sv
`default_nettype none

package msb_pkg;

    localparam int MSB_NUM_STACKS = 3;
    localparam int MSB_DEPTH      = 16;

    localparam int FUNC_W   = 1;
    localparam int SEL_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_REBAL  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_EMPTY  = 3'd3,
        STAT_BADSEL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUSH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/msb_if.sv
`default_nettype none

interface msb_in_if;
    import msb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [SEL_W-1:0]         stack_sel;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output func, output stack_sel, output value, input ready);
    modport sink   (input valid, input func, input stack_sel, input value, output ready);
endinterface

interface msb_out_if;
    import msb_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/msb_ram.sv
`default_nettype none

module msb_ram #(
    parameter int WIDTH = msb_pkg::WORD_W,
    parameter int DEPTH = msb_pkg::MSB_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/multi_stack_shared_buffer.sv
// Channel | Dir | Payload                   | Beat taken when
// i_in    | in  | func, stack_sel, value    | valid && ready
// o_out   | out | status                    | valid && ready
//
// One item at a time: a beat is taken only in idle, and no new beat is taken until its result
// is in the output register. A pop, a plain push or a bad stack select is settled in the
// decide state; a push to a full stack scans the other stacks in turn for a spare slot and
// reports full if none has one. A rebalancing push then moves each stack from the spare one
// back to the one after the pushed one up a slot, one word per read/write pair, then pushes.
// Synchronous reset sets the even split at once; the word store is not cleared. Decoding
// holds while an earlier result still waits on o_out.ready, adding those cycles.
`default_nettype none

module multi_stack_shared_buffer #(
    parameter int NUM_STACKS = msb_pkg::MSB_NUM_STACKS,
    parameter int DEPTH      = msb_pkg::MSB_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msb_in_if.sink     i_in,
    msb_out_if.source  o_out
);
    import msb_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int PART = DEPTH / NUM_STACKS;
    localparam int REST = DEPTH % NUM_STACKS;

    function automatic int reset_base(input int i);
        int b;
        b = i * PART + ((i < REST) ? i : REST);
        return (b >= DEPTH) ? b - DEPTH : b;
    endfunction

    function automatic int reset_size(input int i);
        return PART + ((i < REST) ? 1 : 0);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic logic [SW-1:0] stack_next(input logic [SW-1:0] j);
        return (j == SW'(NUM_STACKS - 1)) ? '0 : j + SW'(1);
    endfunction

    function automatic logic [SW-1:0] stack_prev(input logic [SW-1:0] j);
        return (j == '0) ? SW'(NUM_STACKS - 1) : j - SW'(1);
    endfunction

    t_state r_state, n_state;

    logic [AW-1:0] r_base  [NUM_STACKS];
    logic [AW-1:0] r_limit [NUM_STACKS];
    logic [AW-1:0] r_top   [NUM_STACKS];
    logic [CW-1:0] r_count [NUM_STACKS];
    logic [CW-1:0] r_cap   [NUM_STACKS];

    logic              r_out_valid;
    t_status           r_status;

    logic [FUNC_W-1:0] r_func;
    logic              r_sel_ok;
    logic [SW-1:0]     r_sel;
    logic [WORD_W-1:0] r_value;
    logic [SW-1:0]     r_cand;
    logic [SW-1:0]     r_cur;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_left;

    logic              w_slot_free;
    logic              w_sel_full;
    logic              w_cand_free;
    logic [SW-1:0]     w_next_cand;
    logic [SW-1:0]     w_prev_cur;
    logic              w_shift_done;
    logic              w_res_valid;
    t_status           w_res_status;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WORD_W-1:0] w_rdata;

    msb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_slot_free  = !r_out_valid || o_out.ready;
        w_sel_full   = r_count[r_sel] >= r_cap[r_sel];
        w_cand_free  = r_count[r_cand] < r_cap[r_cand];
        w_next_cand  = stack_next(r_cand);
        w_prev_cur   = stack_prev(r_cur);
        w_shift_done = (r_left == '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_slot_free) begin
                    if (r_sel_ok && r_func == FUNC_PUSH && w_sel_full &&
                        stack_next(r_sel) != r_sel) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (w_cand_free) begin
                    n_state = ST_SHIFT_RD;
                end else if (w_next_cand == r_sel) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT_RD: begin
                if (!w_shift_done) begin
                    n_state = ST_SHIFT_WR;
                end else if (w_prev_cur == r_sel) begin
                    n_state = ST_PUSH;
                end
            end
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_PUSH:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_top[r_sel];
        w_wdata      = r_value;
        w_raddr      = ptr_dec(r_ptr);
        w_res_valid  = 1'b0;
        w_res_status = STAT_OK;
        case (r_state)
            ST_DECIDE: begin
                if (w_slot_free) begin
                    if (!r_sel_ok) begin
                        w_res_valid  = 1'b1;
                        w_res_status = STAT_BADSEL;
                    end else if (r_func == FUNC_POP) begin
                        w_res_valid  = 1'b1;
                        w_res_status = (r_count[r_sel] == '0) ? STAT_EMPTY : STAT_OK;
                    end else if (!w_sel_full) begin
                        w_we         = 1'b1;
                        w_res_valid  = 1'b1;
                        w_res_status = STAT_OK;
                    end else if (stack_next(r_sel) == r_sel) begin
                        w_res_valid  = 1'b1;
                        w_res_status = STAT_FULL;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_cand_free && w_next_cand == r_sel) begin
                    w_res_valid  = 1'b1;
                    w_res_status = STAT_FULL;
                end
            end
            ST_SHIFT_WR: begin
                // move the word read last cycle one slot up
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = w_rdata;
            end
            ST_PUSH: begin
                w_we         = 1'b1;
                w_res_valid  = 1'b1;
                w_res_status = STAT_REBAL;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_base[i]  <= AW'(reset_base(i));
                r_top[i]   <= AW'(reset_base(i));
                r_limit[i] <= AW'(reset_base(i + 1));
                r_count[i] <= '0;
                r_cap[i]   <= CW'(reset_size(i));
            end
        end else begin
            r_state <= n_state;

            if (w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_DECIDE: begin
                    if (w_slot_free && r_sel_ok) begin
                        if (r_func == FUNC_POP) begin
                            if (r_count[r_sel] != '0) begin
                                r_top[r_sel]   <= ptr_dec(r_top[r_sel]);
                                r_count[r_sel] <= r_count[r_sel] - CW'(1);
                            end
                        end else if (!w_sel_full) begin
                            r_top[r_sel]   <= ptr_inc(r_top[r_sel]);
                            r_count[r_sel] <= r_count[r_sel] + CW'(1);
                        end
                    end
                end
                ST_SHIFT_RD: begin
                    if (w_shift_done) begin
                        // stack fully moved: advance its base and top, and its limit unless it gave up the slot
                        r_base[r_cur] <= ptr_inc(r_base[r_cur]);
                        r_top[r_cur]  <= ptr_inc(r_top[r_cur]);
                        if (r_cur == r_cand) begin
                            r_cap[r_cur] <= r_cap[r_cur] - CW'(1);
                        end else begin
                            r_limit[r_cur] <= ptr_inc(r_limit[r_cur]);
                        end
                    end
                end
                ST_PUSH: begin
                    r_limit[r_sel] <= ptr_inc(r_limit[r_sel]);
                    r_cap[r_sel]   <= r_cap[r_sel] + CW'(1);
                    r_top[r_sel]   <= ptr_inc(r_top[r_sel]);
                    r_count[r_sel] <= r_count[r_sel] + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_status <= w_res_status;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_func   <= i_in.func;
                    r_sel_ok <= (32'(i_in.stack_sel) < NUM_STACKS);
                    r_sel    <= SW'(i_in.stack_sel);
                    r_value  <= i_in.value;
                end
            end
            ST_DECIDE: begin
                r_cand <= stack_next(r_sel);
            end
            ST_SCAN: begin
                if (w_cand_free) begin
                    r_cur  <= r_cand;
                    r_ptr  <= r_top[r_cand];
                    r_left <= r_count[r_cand];
                end else begin
                    r_cand <= w_next_cand;
                end
            end
            ST_SHIFT_RD: begin
                if (w_shift_done) begin
                    // load the next stack down towards the pushed one
                    r_cur  <= w_prev_cur;
                    r_ptr  <= r_top[w_prev_cur];
                    r_left <= r_count[w_prev_cur];
                end
            end
            ST_SHIFT_WR: begin
                r_ptr  <= ptr_dec(r_ptr);
                r_left <= r_left - CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready   = (r_state == ST_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;

endmodule

`default_nettype wire

// File: dv/tb_multi_stack_shared_buffer.sv
`timescale 1ns / 1ps

module tb_multi_stack_shared_buffer;
    import msb_pkg::*;

    localparam int NS         = MSB_NUM_STACKS;
    localparam int WORDS      = MSB_DEPTH;
    localparam int RAND_ITEMS = 800;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_WAIT  = 2 * WORDS + NS + 8;

    // Tracks per-stack fill and slot ownership and predicts the status of each request.
    class stack_status_board;
        int unsigned fill[NS];
        int unsigned slots[NS];
        t_status     status_due[$];
        int unsigned results_seen;

        function new();
            for (int i = 0; i < NS; i++) begin
                fill[i]  = 0;
                slots[i] = WORDS / NS + ((i < WORDS % NS) ? 1 : 0);
            end
            results_seen = 0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [SEL_W-1:0] sel);
            int s;
            int c;
            t_status st;
            s = int'(sel);
            if (s >= NS) begin
                st = STAT_BADSEL;
            end else if (func == FUNC_POP) begin
                if (fill[s] == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    fill[s]--;
                    st = STAT_OK;
                end
            end else if (fill[s] < slots[s]) begin
                fill[s]++;
                st = STAT_OK;
            end else begin
                // search forward, circularly, for a stack with a spare slot
                c = (s + 1) % NS;
                while (c != s && fill[c] >= slots[c])
                    c = (c + 1) % NS;
                if (c == s) begin
                    st = STAT_FULL;
                end else begin
                    slots[c]--;
                    slots[s]++;
                    fill[s]++;
                    st = STAT_REBAL;
                end
            end
            status_due.push_back(st);
        endfunction

        function bit check_result(logic [STATUS_W-1:0] got, output string why);
            t_status want;
            results_seen++;
            if (status_due.size() == 0) begin
                why = $sformatf("result %0d: status %0d with nothing pending", results_seen, got);
                return 1'b0;
            end
            want = status_due.pop_front();
            if (got !== want) begin
                why = $sformatf("result %0d: status %0d, want %0d (%s)",
                                results_seen, got, want, want.name());
                return 1'b0;
            end
            why = "";
            return 1'b1;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    msb_in_if  in_if ();
    msb_out_if out_if ();

    multi_stack_shared_buffer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    stack_status_board board = new();
    int unsigned       mismatches = 0;
    int unsigned       burst_left = 4;
    int unsigned       idle_cycles = 0;
    int unsigned       rx_phase = 0;
    int unsigned       rx_mode = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(string why);
        $display("MISMATCH @%0t: %s", $realtime, why);
        mismatches++;
    endtask

    // Hold the beat until taken, then maybe close the burst with a gap.
    task automatic send_item(logic [FUNC_W-1:0] func, logic [SEL_W-1:0] sel,
                             logic [WORD_W-1:0] value);
        in_if.valid     <= 1'b1;
        in_if.func      <= func;
        in_if.stack_sel <= sel;
        in_if.value     <= value;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Receiver stall pattern, with a style picked at random.
    always @(negedge i_clk) begin
        logic rdy;
        rx_phase++;
        if (rx_phase % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = (rx_phase % 3 == 0);
            2: rdy = 1'($urandom_range(0, 1));
            default: rdy = (rx_phase % 8) < 5;
        endcase
        out_if.ready <= rdy;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            board.note_request(in_if.func, in_if.stack_sel);
    end

    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (!board.check_result(out_if.status, why))
                report_mismatch(why);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] edge_words[6];
        int                push_pct;
        int                hot_sel;
        int                hot_pct;
        logic [FUNC_W-1:0] f;
        logic [SEL_W-1:0]  s;

        edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                       32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.func      = FUNC_PUSH;
        in_if.stack_sel = '0;
        in_if.value     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pops on empty stacks, then an out-of-range stack for both operations
        for (int i = 0; i < NS; i++)
            send_item(FUNC_POP, SEL_W'(i), $urandom());
        send_item(FUNC_PUSH, 2'd3, 32'hFFFF_FFFF);
        send_item(FUNC_POP, 2'd3, 32'h0000_0000);
        // fill the last stack until it owns the whole store, wrapping the search, then overflow
        for (int i = 0; i <= WORDS; i++)
            send_item(FUNC_PUSH, SEL_W'(NS - 1), (i < 6) ? edge_words[i] : $urandom());
        send_item(FUNC_POP, SEL_W'(NS - 1), $urandom());
        // stack owning no slot takes one back
        send_item(FUNC_PUSH, 2'd0, 32'h8000_0000);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 55;
                    default: push_pct = 15;
                endcase
                hot_sel = $urandom_range(0, NS - 1);
                hot_pct = $urandom_range(0, 80);
            end
            f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
            if ($urandom_range(0, 99) < 4)
                s = 2'd3;
            else if ($urandom_range(0, 99) < hot_pct)
                s = SEL_W'(hot_sel);
            else
                s = SEL_W'($urandom_range(0, NS - 1));
            send_item(f, s, $urandom());
        end
        in_if.valid <= 1'b0;

        while (board.status_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatches == 0 && board.status_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: multi_stack_shared_buffer.f
rtl/core/msb_pkg.sv
rtl/core/msb_if.sv
rtl/core/msb_ram.sv
rtl/core/multi_stack_shared_buffer.sv
dv/tb_multi_stack_shared_buffer.sv
